// ===== rtl/core/windowed_sample_statistics_unit_defines.svh =====
// assertion macros for the windowed sample statistics checker
// expects clk and rst_n in the scope where a macro is used
`ifndef WINDOWED_SAMPLE_STATISTICS_UNIT_DEFINES_SVH
`define WINDOWED_SAMPLE_STATISTICS_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define WSS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wss port check failed");

// next-cycle implication, disabled during reset
`define WSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wss port check failed");

`endif

// ===== rtl/core/wss_pkg.sv =====
// shared constants, types and state codes for the windowed sample statistics unit
// no dependencies
`default_nettype none
package wss_pkg;
  localparam int STORE_DEPTH = 128;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int IDX_W       = CNT_W + 1;
  localparam int ERR_W       = 16;
  localparam int TIME_W      = 32;
  localparam int WIN_W       = 8;
  localparam int VAR_W       = 32;
  localparam int SLOPE_W     = 32;
  localparam int FRAC_W      = 16;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 8;

  // accumulator widths, grown by the store depth
  localparam int SX_W  = TIME_W + ADDR_W + 1;
  localparam int SY_W  = ERR_W + ADDR_W + 1;
  localparam int SXY_W = TIME_W + ERR_W + ADDR_W + 1;
  localparam int SXX_W = 2 * TIME_W + ADDR_W + 1;
  localparam int SY2_W = 2 * ERR_W + ADDR_W + 1;

  // shared unit width: covers n*sxx and the shifted slope numerator
  localparam int ALU_A  = SXX_W + CNT_W;
  localparam int ALU_B  = SXY_W + CNT_W + FRAC_W + 1;
  localparam int ALU_W  = (ALU_A > ALU_B) ? ALU_A : ALU_B;
  localparam int MUL_STEPS = SX_W;
  localparam int STEP_W = $clog2(ALU_W + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_WINDOW = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_WINDOW  = CFG_IDX_W'(1);
  localparam logic [WIN_W-1:0] SHORT_RESET = WIN_W'(20);
  localparam logic [WIN_W-1:0] LONG_RESET  = WIN_W'(100);

  // request codes
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WALK, ST_MEAN, ST_VMUL1, ST_VMUL2, ST_VDIV,
    ST_SMUL1, ST_SMUL2, ST_SMUL3, ST_SMUL4, ST_SDIV, ST_FIN
  } wss_state_t;

  typedef enum logic {ALU_MUL, ALU_DIV} wss_op_t;

  typedef struct packed {
    logic    start;
    wss_op_t op;
  } wss_alu_ctrl_t;

  // per-entry walk tag: valid, in short window, in long window
  typedef struct packed {
    logic v;
    logic s;
    logic l;
  } wss_tag_t;

  typedef struct packed {
    logic signed [SX_W-1:0]  sx;
    logic signed [SY_W-1:0]  sy;
    logic signed [SXY_W-1:0] sxy;
    logic        [SXX_W-1:0] sxx;
  } wss_sums_t;
endpackage
`default_nettype wire

// ===== rtl/core/windowed_sample_statistics_unit.sv =====
// a clear transaction goes from idle through ST_FIN to its result; an add walks the newest
// m entries of the store, m = larger of the two windows (at most 128), then runs the shared
// multiply/divide unit (one bit per cycle; 10 multiplies and 4 divides per sample)
// throughput: one transaction at a time, in_ready only while idle, plus any out_ready stall
// reset: synchronous active low; clears pointer, count and control, presets the windows, not the store
`default_nettype none
module windowed_sample_statistics_unit (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire                                  in_req_type,
  input  wire  signed [wss_pkg::ERR_W-1:0]     in_error_value,
  input  wire  [wss_pkg::TIME_W-1:0]           in_sample_time,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic signed [wss_pkg::ERR_W-1:0]     out_window_mean,
  output logic [wss_pkg::VAR_W-1:0]            out_window_variance,
  output logic signed [wss_pkg::SLOPE_W-1:0]   out_slope_short,
  output logic signed [wss_pkg::SLOPE_W-1:0]   out_slope_long,
  output logic [wss_pkg::CNT_W-1:0]            out_sample_count,
  input  wire                                  cfg_we,
  input  wire  [wss_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [wss_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import wss_pkg::*;

  wss_state_t          state_r, state_nxt;
  logic [WIN_W-1:0]    short_r, long_r;
  logic [ADDR_W-1:0]   wp_r, wp_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    ns_r, ns_nxt, nl_r, nl_nxt, m_r, m_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic                launched_r, launched_nxt;
  logic                sel_r, sel_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [TIME_W-1:0]   tnew_r, tnew_nxt;
  logic [ALU_W-1:0]    t1_r, t1_nxt, den_r, den_nxt, mag_r, mag_nxt;
  logic                neg_r, neg_nxt;
  logic signed [ERR_W-1:0]   mean_r, mean_nxt;
  logic [VAR_W-1:0]          var_r, var_nxt;
  logic signed [SLOPE_W-1:0] ss_r, ss_nxt, sl_r, sl_nxt;
  logic signed [ERR_W-1:0]   o_mean_r, o_mean_nxt;
  logic [VAR_W-1:0]          o_var_r, o_var_nxt;
  logic signed [SLOPE_W-1:0] o_ss_r, o_ss_nxt, o_sl_r, o_sl_nxt;
  logic [CNT_W-1:0]          o_cnt_r, o_cnt_nxt;

  logic                in_acc;
  logic                acc_clear;
  wss_tag_t            tag_c;
  logic [ADDR_W-1:0]   rd_addr_c;
  logic [ERR_W-1:0]    rd_err;
  logic [TIME_W-1:0]   rd_time;
  wss_sums_t           sums_s, sums_l, cur_c;
  logic [SY2_W-1:0]    sy2_l;
  logic                acc_busy;
  wss_alu_ctrl_t       alu_ctrl;
  logic [ALU_W-1:0]    opa_c, opb_c, alu_res;
  logic                alu_done;
  logic [CNT_W-1:0]    ncur_c;
  logic [ALU_W-1:0]    abs_sx_c, abs_sy_c, abs_sxy_c, abs_syl_c, vn_c;
  logic [2*CNT_W-1:0]  dvar_c;
  logic [ALU_W:0]      p3_c, p4_c, num_c;
  logic [SLOPE_W-1:0]  slope_c;
  logic [ERR_W-1:0]    mq_c;

  assign in_acc    = in_valid & in_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_window_mean     = o_mean_r;
  assign out_window_variance = o_var_r;
  assign out_slope_short     = o_ss_r;
  assign out_slope_long      = o_sl_r;
  assign out_sample_count    = o_cnt_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_r <= SHORT_RESET;
      long_r  <= LONG_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_SHORT_WINDOW) short_r <= WIN_W'(cfg_wdata);
      if (cfg_index == CFG_LONG_WINDOW)  long_r  <= WIN_W'(cfg_wdata);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      cnt_r       <= '0;
      idx_r       <= '0;
      launched_r  <= 1'b0;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      launched_r  <= launched_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    ns_r     <= ns_nxt;
    nl_r     <= nl_nxt;
    m_r      <= m_nxt;
    tnew_r   <= tnew_nxt;
    t1_r     <= t1_nxt;
    den_r    <= den_nxt;
    mag_r    <= mag_nxt;
    neg_r    <= neg_nxt;
    mean_r   <= mean_nxt;
    var_r    <= var_nxt;
    ss_r     <= ss_nxt;
    sl_r     <= sl_nxt;
    o_mean_r <= o_mean_nxt;
    o_var_r  <= o_var_nxt;
    o_ss_r   <= o_ss_nxt;
    o_sl_r   <= o_sl_nxt;
    o_cnt_r  <= o_cnt_nxt;
  end

  wss_store u_store (
    .clk     (clk),
    .wr_en   (in_acc & (in_req_type == REQ_ADD)),
    .wr_addr (wp_r),
    .wr_err  (in_error_value),
    .wr_time (in_sample_time),
    .rd_addr (rd_addr_c),
    .rd_err  (rd_err),
    .rd_time (rd_time)
  );

  wss_accum u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (acc_clear),
    .tag_in  (tag_c),
    .rd_err  (rd_err),
    .rd_time (rd_time),
    .tnew    (tnew_r),
    .sums_s  (sums_s),
    .sums_l  (sums_l),
    .sy2_l   (sy2_l),
    .busy    (acc_busy)
  );

  wss_alu u_alu (
    .clk  (clk),
    .rst_n(rst_n),
    .ctrl (alu_ctrl),
    .opa  (opa_c),
    .opb  (opb_c),
    .res  (alu_res),
    .done (alu_done)
  );

  // walk issue: entry idx back from the write pointer
  always_comb begin
    rd_addr_c = wp_r - idx_r[ADDR_W-1:0];
    tag_c.v   = (state_r == ST_WALK) && (idx_r <= {1'b0, m_r});
    tag_c.s   = idx_r <= {1'b0, ns_r};
    tag_c.l   = idx_r <= {1'b0, nl_r};
  end

  // operand magnitudes for the selected window
  always_comb begin
    cur_c     = sel_r ? sums_l : sums_s;
    ncur_c    = sel_r ? nl_r : ns_r;
    abs_sx_c  = ALU_W'(cur_c.sx[SX_W-1] ? -cur_c.sx : cur_c.sx);
    abs_sy_c  = ALU_W'(cur_c.sy[SY_W-1] ? -cur_c.sy : cur_c.sy);
    abs_sxy_c = ALU_W'(cur_c.sxy[SXY_W-1] ? -cur_c.sxy : cur_c.sxy);
    abs_syl_c = ALU_W'(sums_l.sy[SY_W-1] ? -sums_l.sy : sums_l.sy);
    vn_c      = (t1_r >= alu_res) ? (t1_r - alu_res) : '0;
    dvar_c    = {{CNT_W{1'b0}}, nl_r} * {{CNT_W{1'b0}}, nl_r - 1'b1};
    mq_c      = alu_res[ERR_W-1:0];
    p3_c      = cur_c.sxy[SXY_W-1] ? -{1'b0, t1_r} : {1'b0, t1_r};
    p4_c      = (cur_c.sx[SX_W-1] ^ cur_c.sy[SY_W-1]) ? -{1'b0, alu_res} : {1'b0, alu_res};
    num_c     = p3_c - p4_c;
  end

  // slope saturation from the quotient and the sign
  always_comb begin
    if (!neg_r) begin
      slope_c = (alu_res > ALU_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : alu_res[SLOPE_W-1:0];
    end else begin
      slope_c = (alu_res > ALU_W'(32'h8000_0000)) ? 32'h8000_0000
                                                  : (SLOPE_W'(0) - alu_res[SLOPE_W-1:0]);
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    cnt_nxt       = cnt_r;
    ns_nxt        = ns_r;
    nl_nxt        = nl_r;
    m_nxt         = m_r;
    idx_nxt       = idx_r;
    launched_nxt  = launched_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r;
    tnew_nxt      = tnew_r;
    t1_nxt        = t1_r;
    den_nxt       = den_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    mean_nxt      = mean_r;
    var_nxt       = var_r;
    ss_nxt        = ss_r;
    sl_nxt        = sl_r;
    o_mean_nxt    = o_mean_r;
    o_var_nxt     = o_var_r;
    o_ss_nxt      = o_ss_r;
    o_sl_nxt      = o_sl_r;
    o_cnt_nxt     = o_cnt_r;
    acc_clear     = 1'b0;
    alu_ctrl.start = 1'b0;
    alu_ctrl.op    = ALU_MUL;
    opa_c          = '0;
    opb_c          = '0;

    // result register drains independently
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_req_type == REQ_CLEAR) begin
            wp_nxt    = '0;
            cnt_nxt   = '0;
            mean_nxt  = '0;
            var_nxt   = '0;
            ss_nxt    = '0;
            sl_nxt    = '0;
            state_nxt = ST_FIN;
          end else begin
            wp_nxt   = wp_r + 1'b1;
            cnt_nxt  = (cnt_r < CNT_W'(STORE_DEPTH)) ? cnt_r + 1'b1 : cnt_r;
            ns_nxt   = ({{CNT_W{1'b0}}, short_r} < {{WIN_W{1'b0}}, cnt_nxt})
                       ? CNT_W'(short_r) : cnt_nxt;
            nl_nxt   = ({{CNT_W{1'b0}}, long_r} < {{WIN_W{1'b0}}, cnt_nxt})
                       ? CNT_W'(long_r) : cnt_nxt;
            m_nxt    = (ns_nxt > nl_nxt) ? ns_nxt : nl_nxt;
            tnew_nxt = in_sample_time;
            idx_nxt  = IDX_W'(1);
            sel_nxt  = 1'b0;
            acc_clear = 1'b1;
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (idx_r <= {1'b0, m_r}) begin
          idx_nxt = idx_r + 1'b1;
        end else if (!acc_busy) begin
          state_nxt = ST_MEAN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          o_mean_nxt    = mean_r;
          o_var_nxt     = var_r;
          o_ss_nxt      = ss_r;
          o_sl_nxt      = sl_r;
          o_cnt_nxt     = cnt_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        // arithmetic steps on the shared unit
        case (state_r)
          ST_MEAN: begin
            alu_ctrl.op = ALU_DIV;
            opa_c = abs_syl_c;
            opb_c = ALU_W'(nl_r);
          end
          ST_VMUL1: begin
            opa_c = ALU_W'(sy2_l);
            opb_c = ALU_W'(nl_r);
          end
          ST_VMUL2: begin
            opa_c = abs_syl_c;
            opb_c = abs_syl_c;
          end
          ST_VDIV: begin
            alu_ctrl.op = ALU_DIV;
            opa_c = t1_r;
            opb_c = ALU_W'(dvar_c);
          end
          ST_SMUL1: begin
            opa_c = ALU_W'(cur_c.sxx);
            opb_c = ALU_W'(ncur_c);
          end
          ST_SMUL2: begin
            opa_c = abs_sx_c;
            opb_c = abs_sx_c;
          end
          ST_SMUL3: begin
            opa_c = abs_sxy_c;
            opb_c = ALU_W'(ncur_c);
          end
          ST_SMUL4: begin
            opa_c = abs_sx_c;
            opb_c = abs_sy_c;
          end
          ST_SDIV: begin
            alu_ctrl.op = ALU_DIV;
            opa_c = mag_r << FRAC_W;
            opb_c = den_r;
          end
          default: begin
            opa_c = '0;
          end
        endcase

        if (!launched_r) begin
          alu_ctrl.start = 1'b1;
          launched_nxt   = 1'b1;
        end else if (alu_done) begin
          launched_nxt = 1'b0;
          case (state_r)
            ST_MEAN: begin
              if (nl_r == '0) mean_nxt = '0;
              else mean_nxt = sums_l.sy[SY_W-1] ? $signed(ERR_W'(0) - mq_c) : $signed(mq_c);
              state_nxt = ST_VMUL1;
            end
            ST_VMUL1: begin
              t1_nxt    = alu_res;
              state_nxt = ST_VMUL2;
            end
            ST_VMUL2: begin
              t1_nxt    = vn_c;
              state_nxt = ST_VDIV;
            end
            ST_VDIV: begin
              if (nl_r < CNT_W'(2)) var_nxt = '0;
              else if (alu_res > ALU_W'(32'hFFFF_FFFF)) var_nxt = '1;
              else var_nxt = alu_res[VAR_W-1:0];
              state_nxt = ST_SMUL1;
            end
            ST_SMUL1: begin
              t1_nxt    = alu_res;
              state_nxt = ST_SMUL2;
            end
            ST_SMUL2: begin
              den_nxt   = t1_r - alu_res;
              state_nxt = ST_SMUL3;
            end
            ST_SMUL3: begin
              t1_nxt    = alu_res;
              state_nxt = ST_SMUL4;
            end
            ST_SMUL4: begin
              neg_nxt   = num_c[ALU_W];
              mag_nxt   = num_c[ALU_W] ? (ALU_W'(0) - num_c[ALU_W-1:0]) : num_c[ALU_W-1:0];
              state_nxt = ST_SDIV;
            end
            ST_SDIV: begin
              if (sel_r) begin
                sl_nxt    = (ncur_c < CNT_W'(2) || den_r == '0) ? '0 : $signed(slope_c);
                state_nxt = ST_FIN;
              end else begin
                ss_nxt    = (ncur_c < CNT_W'(2) || den_r == '0) ? '0 : $signed(slope_c);
                sel_nxt   = 1'b1;
                state_nxt = ST_SMUL1;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/core/wss_store.sv =====
// ring store of error samples and timestamps, one write and one registered read port
// depends on wss_pkg
`default_nettype none
module wss_store (
  input  wire                             clk,
  input  wire                             wr_en,
  input  wire  [wss_pkg::ADDR_W-1:0]      wr_addr,
  input  wire  [wss_pkg::ERR_W-1:0]       wr_err,
  input  wire  [wss_pkg::TIME_W-1:0]      wr_time,
  input  wire  [wss_pkg::ADDR_W-1:0]      rd_addr,
  output logic [wss_pkg::ERR_W-1:0]       rd_err,
  output logic [wss_pkg::TIME_W-1:0]      rd_time
);
  import wss_pkg::*;

  logic [ERR_W-1:0]  err_mem [STORE_DEPTH];
  logic [TIME_W-1:0] time_mem [STORE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      err_mem[wr_addr]  <= wr_err;
      time_mem[wr_addr] <= wr_time;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_err  <= err_mem[rd_addr];
    rd_time <= time_mem[rd_addr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/wss_accum.sv =====
// window accumulator: products then sums over the entries walked from the store
// depends on wss_pkg
`default_nettype none
module wss_accum (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              clear,
  input  wire  wss_pkg::wss_tag_t          tag_in,
  input  wire  [wss_pkg::ERR_W-1:0]        rd_err,
  input  wire  [wss_pkg::TIME_W-1:0]       rd_time,
  input  wire  [wss_pkg::TIME_W-1:0]       tnew,
  output wss_pkg::wss_sums_t               sums_s,
  output wss_pkg::wss_sums_t               sums_l,
  output logic [wss_pkg::SY2_W-1:0]        sy2_l,
  output logic                             busy
);
  import wss_pkg::*;

  wss_tag_t tag1_r, tag2_r;
  logic signed [TIME_W-1:0]        x_r;
  logic signed [ERR_W-1:0]         y_r;
  logic signed [TIME_W+ERR_W-1:0]  pxy_r;
  logic        [2*TIME_W-1:0]      pxx_r;
  logic        [2*ERR_W-1:0]       pyy_r;
  logic signed [TIME_W-1:0]        x_c;
  logic signed [ERR_W-1:0]         y_c;
  logic        [TIME_W-1:0]        ax_c;
  logic signed [2*ERR_W-1:0]       yy_c;
  wss_sums_t                       add_c;

  // tags follow the store's read latency, then the product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
    end else begin
      tag1_r <= tag_in;
      tag2_r <= tag1_r;
    end
  end

  // time relative to the newest sample, read as signed
  always_comb begin
    x_c  = $signed(rd_time - tnew);
    y_c  = $signed(rd_err);
    ax_c = x_c[TIME_W-1] ? (TIME_W'(0) - rd_time + tnew) : (rd_time - tnew);
    yy_c = y_c * y_c;
  end

  // product stage
  always_ff @(posedge clk) begin
    x_r   <= x_c;
    y_r   <= y_c;
    pxy_r <= x_c * y_c;
    pxx_r <= {{TIME_W{1'b0}}, ax_c} * {{TIME_W{1'b0}}, ax_c};
    pyy_r <= yy_c;
  end

  // one entry's contribution, extended to the sum widths
  always_comb begin
    add_c.sx  = SX_W'(x_r);
    add_c.sy  = SY_W'(y_r);
    add_c.sxy = SXY_W'(pxy_r);
    add_c.sxx = SXX_W'(pxx_r);
  end

  // sum stage
  always_ff @(posedge clk) begin
    if (clear) begin
      sums_s <= '0;
      sums_l <= '0;
      sy2_l  <= '0;
    end else if (tag2_r.v) begin
      if (tag2_r.s) begin
        sums_s.sx  <= sums_s.sx + add_c.sx;
        sums_s.sy  <= sums_s.sy + add_c.sy;
        sums_s.sxy <= sums_s.sxy + add_c.sxy;
        sums_s.sxx <= sums_s.sxx + add_c.sxx;
      end
      if (tag2_r.l) begin
        sums_l.sx  <= sums_l.sx + add_c.sx;
        sums_l.sy  <= sums_l.sy + add_c.sy;
        sums_l.sxy <= sums_l.sxy + add_c.sxy;
        sums_l.sxx <= sums_l.sxx + add_c.sxx;
        sy2_l      <= sy2_l + SY2_W'(pyy_r);
      end
    end
  end

  assign busy = tag1_r.v | tag2_r.v;
endmodule
`default_nettype wire

// ===== rtl/core/wss_alu.sv =====
// shared shift-add multiplier and restoring divider, one bit per cycle
// depends on wss_pkg
`default_nettype none
module wss_alu (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire  wss_pkg::wss_alu_ctrl_t    ctrl,
  input  wire  [wss_pkg::ALU_W-1:0]       opa,
  input  wire  [wss_pkg::ALU_W-1:0]       opb,
  output logic [wss_pkg::ALU_W-1:0]       res,
  output logic                            done
);
  import wss_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  wss_op_t             op_r, op_nxt;
  logic [STEP_W-1:0]   cnt_r, cnt_nxt;
  logic [ALU_W:0]      acc_r, acc_nxt;
  logic [ALU_W-1:0]    a_r, a_nxt;
  logic [ALU_W-1:0]    b_r, b_nxt;
  logic [ALU_W:0]      r2_c;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  // one multiply or divide step per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    r2_c     = {acc_r[ALU_W-1:0], b_r[ALU_W-1]};
    if (ctrl.start) begin
      busy_nxt = 1'b1;
      op_nxt   = ctrl.op;
      acc_nxt  = '0;
      case (ctrl.op)
        ALU_MUL: begin
          a_nxt   = opa;
          b_nxt   = opb;
          cnt_nxt = STEP_W'(MUL_STEPS);
        end
        ALU_DIV: begin
          a_nxt   = opb;
          b_nxt   = opa;
          cnt_nxt = STEP_W'(ALU_W);
        end
        default: begin
          a_nxt   = opa;
          b_nxt   = opb;
          cnt_nxt = STEP_W'(MUL_STEPS);
        end
      endcase
    end else if (busy_r) begin
      case (op_r)
        ALU_MUL: begin
          if (b_r[0]) acc_nxt = acc_r + {1'b0, a_r};
          a_nxt = {a_r[ALU_W-2:0], 1'b0};
          b_nxt = {1'b0, b_r[ALU_W-1:1]};
        end
        ALU_DIV: begin
          if (r2_c >= {1'b0, a_r}) begin
            acc_nxt = r2_c - {1'b0, a_r};
            b_nxt   = {b_r[ALU_W-2:0], 1'b1};
          end else begin
            acc_nxt = r2_c;
            b_nxt   = {b_r[ALU_W-2:0], 1'b0};
          end
        end
        default: begin
          acc_nxt = acc_r;
        end
      endcase
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign res  = (op_r == ALU_DIV) ? b_r : acc_r[ALU_W-1:0];
  assign done = done_r;
endmodule
`default_nettype wire

// ===== rtl/core/wss_checker.sv =====
// port-level checks for the windowed sample statistics unit, bound to the top level
// depends on wss_pkg and windowed_sample_statistics_unit_defines.svh
`default_nettype none
`include "windowed_sample_statistics_unit_defines.svh"
module wss_checker (
  input wire                                  clk,
  input wire                                  rst_n,
  input wire                                  in_valid,
  input wire                                  in_ready,
  input wire                                  in_req_type,
  input wire signed [wss_pkg::ERR_W-1:0]      in_error_value,
  input wire [wss_pkg::TIME_W-1:0]            in_sample_time,
  input wire                                  out_valid,
  input wire                                  out_ready,
  input wire signed [wss_pkg::ERR_W-1:0]      out_window_mean,
  input wire [wss_pkg::VAR_W-1:0]             out_window_variance,
  input wire signed [wss_pkg::SLOPE_W-1:0]    out_slope_short,
  input wire signed [wss_pkg::SLOPE_W-1:0]    out_slope_long,
  input wire [wss_pkg::CNT_W-1:0]             out_sample_count,
  input wire                                  cfg_we,
  input wire [wss_pkg::CFG_IDX_W-1:0]         cfg_index,
  input wire [wss_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
  import wss_pkg::*;

  // a stalled result holds
  `WSS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_slope_long) && $stable(out_window_mean))

  // one transaction at a time: busy right after acceptance
  `WSS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // count never passes the store depth
  `WSS_ASSERT_SAME(a_count_range, out_valid, out_sample_count <= CNT_W'(STORE_DEPTH))

  // under two samples there is no variance and no slope
  `WSS_ASSERT_SAME(a_small_window, out_valid && out_sample_count < CNT_W'(2), out_window_variance == '0 && out_slope_short == '0 && out_slope_long == '0)
endmodule

bind windowed_sample_statistics_unit wss_checker u_wss_checker (.*);
`default_nettype wire

// ===== bench/windowed_sample_statistics_unit_tb.sv =====
// testbench for windowed_sample_statistics_unit: random and directed transactions,
// checked against an in-bench predictor of mean, variance and slopes; needs wss_pkg
`timescale 1ns / 1ps

module windowed_sample_statistics_unit_tb;
  import wss_pkg::*;

  typedef struct {
    logic signed [ERR_W-1:0]   mean;
    logic [VAR_W-1:0]          variance;
    logic signed [SLOPE_W-1:0] slope_s;
    logic signed [SLOPE_W-1:0] slope_l;
    logic [CNT_W-1:0]          count;
  } stats_t;

  // predictor of the block plus the store of expected results
  class stats_scoreboard;
    logic signed [ERR_W-1:0] err_mem[STORE_DEPTH];
    logic [TIME_W-1:0]       time_mem[STORE_DEPTH];
    int unsigned wptr, filled, short_w, long_w;
    stats_t      pending[$];
    int          failures;

    function new();
      wptr = 0; filled = 0; short_w = SHORT_RESET; long_w = LONG_RESET; failures = 0;
    endfunction

    function void set_window(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_SHORT_WINDOW) short_w = val;
      else if (idx == CFG_LONG_WINDOW) long_w = val;
    endfunction

    function int unsigned slot(int unsigned back);
      return (wptr + STORE_DEPTH - back) % STORE_DEPTH;
    endfunction

    function int unsigned span(int unsigned w);
      return (w < filled) ? w : filled;
    endfunction

    // least-squares slope over the newest samples, Q16.16, saturated
    function logic [SLOPE_W-1:0] fit_slope(int unsigned w);
      int unsigned n, idx;
      logic [TIME_W-1:0] tnew, d;
      logic signed [127:0] nn, x, y, sx, sy, sxy, sxx, den, num;
      logic [127:0] mag, shifted, udn;
      logic [31:0] q;
      bit neg;
      n = span(w);
      if (n < 2) return '0;
      tnew = time_mem[slot(1)];
      nn = n; sx = 0; sy = 0; sxy = 0; sxx = 0;
      for (int i = n; i >= 1; i--) begin
        idx = slot(i);
        d = time_mem[idx] - tnew;
        x = $signed(d);
        y = err_mem[idx];
        sx += x; sy += y; sxy += x * y; sxx += x * x;
      end
      den = nn * sxx - sx * sx;
      if (den == 0) return '0;
      num = nn * sxy - sx * sy;
      neg = num < 0;
      mag = neg ? -num : num;
      shifted = mag << 16;
      udn = den;
      if (shifted >= (udn << 32)) q = 32'hFFFF_FFFF;
      else q = shifted / udn;
      if (!neg) return (q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q;
      if (q > 32'h8000_0000) q = 32'h8000_0000;
      return -q;
    endfunction

    // accepted input transaction: update state and queue its result
    function void note(logic req, logic signed [ERR_W-1:0] ev, logic [TIME_W-1:0] t);
      stats_t r;
      int unsigned n;
      logic signed [127:0] nn, y, sy, sy2, vn, v;
      if (req == REQ_CLEAR) begin
        wptr = 0; filled = 0;
        r.mean = '0; r.variance = '0; r.slope_s = '0; r.slope_l = '0; r.count = '0;
        pending.push_back(r);
        return;
      end
      err_mem[wptr] = ev;
      time_mem[wptr] = t;
      wptr = (wptr + 1) % STORE_DEPTH;
      if (filled < STORE_DEPTH) filled++;
      n = span(long_w);
      nn = n; sy = 0; sy2 = 0;
      for (int i = 1; i <= n; i++) begin
        y = err_mem[slot(i)];
        sy += y; sy2 += y * y;
      end
      r.mean = (n > 0) ? ERR_W'(sy / nn) : '0;
      r.variance = '0;
      if (n > 1) begin
        vn = nn * sy2 - sy * sy;
        if (vn < 0) vn = 0;
        v = vn / (nn * (nn - 1));
        r.variance = (v > 128'shFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
      end
      r.slope_s = fit_slope(short_w);
      r.slope_l = fit_slope(long_w);
      r.count = CNT_W'(filled);
      pending.push_back(r);
    endfunction

    function void check(stats_t got);
      stats_t e;
      if (pending.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected result transaction, none pending");
        return;
      end
      e = pending.pop_front();
      if (got.mean !== e.mean || got.variance !== e.variance || got.slope_s !== e.slope_s ||
          got.slope_l !== e.slope_l || got.count !== e.count) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: exp mean %0d var %0d ss %0d sl %0d n %0d / got %0d %0d %0d %0d %0d",
                   e.mean, e.variance, e.slope_s, e.slope_l, e.count,
                   got.mean, got.variance, got.slope_s, got.slope_l, got.count);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_req_type = REQ_ADD;
  logic signed [ERR_W-1:0] in_error_value = '0;
  logic [TIME_W-1:0] in_sample_time = '0;
  logic out_ready = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  wire in_ready, out_valid;
  wire signed [ERR_W-1:0] out_window_mean;
  wire [VAR_W-1:0] out_window_variance;
  wire signed [SLOPE_W-1:0] out_slope_short, out_slope_long;
  wire [CNT_W-1:0] out_sample_count;

  stats_scoreboard sb = new();
  bit calm = 1'b0;
  logic [TIME_W-1:0] tcur = '0;
  longint unsigned cycles = 0;

  windowed_sample_statistics_unit dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // timeout guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd10_000_000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // transaction monitors
  always @(posedge clk) begin
    stats_t got;
    if (rst_n && in_valid && in_ready) sb.note(in_req_type, in_error_value, in_sample_time);
    if (rst_n && out_valid && out_ready) begin
      got.mean = out_window_mean; got.variance = out_window_variance;
      got.slope_s = out_slope_short; got.slope_l = out_slope_long;
      got.count = out_sample_count;
      sb.check(got);
    end
  end

  // receiver stalls, mostly short with an occasional long one
  always @(posedge clk) begin
    int stall_left;
    if (calm) begin
      out_ready <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 99) < 70) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
    end
  end

  task automatic send(logic req, logic signed [ERR_W-1:0] ev, logic [TIME_W-1:0] t);
    int gap;
    gap = calm ? 0 : ($urandom_range(0, 19) == 0 ? $urandom_range(20, 80)
                                                 : $urandom_range(0, 9) < 6 ? 0
                                                 : $urandom_range(1, 3));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_error_value <= ev;
    in_sample_time <= t;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_window(idx, val);
  endtask

  task automatic add_random();
    int pick;
    logic signed [ERR_W-1:0] ev;
    pick = $urandom_range(0, 99);
    if (pick < 1) begin
      send(REQ_CLEAR, ERR_W'($urandom), $urandom);
      return;
    end
    if (pick < 4) tcur = $urandom;
    else if (pick < 6) tcur = tcur - $urandom_range(1, 5000);
    else if (pick < 10) tcur = tcur;
    else if (pick < 70) tcur = tcur + $urandom_range(1, 10000);
    else tcur = tcur + $urandom_range(1, 8);
    case ($urandom_range(0, 9))
      0: ev = 16'sh7FFF;
      1: ev = -16'sh8000;
      2, 3: ev = ERR_W'($signed(tcur[11:0]) * 4);
      default: ev = ERR_W'($urandom);
    endcase
    send(REQ_ADD, ev, tcur);
  endtask

  initial begin
    logic [7:0] wins[7][2];
    wins = '{'{8'd20, 8'd100}, '{8'd0, 8'd0}, '{8'd1, 8'd128}, '{8'd128, 8'd2},
             '{8'd255, 8'd255}, '{8'd5, 8'd37}, '{8'd128, 8'd128}};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty clear, extremes, equal and wrapped timestamps
    send(REQ_CLEAR, '0, '0);
    send(REQ_ADD, 16'sh7FFF, 32'd0);
    send(REQ_ADD, -16'sh8000, 32'd0);
    send(REQ_ADD, 16'sh7FFF, 32'd0);
    send(REQ_ADD, 16'sd0, 32'd100);
    send(REQ_ADD, -16'sh8000, 32'd200);
    send(REQ_ADD, 16'sd100, 32'd300);
    send(REQ_ADD, 16'sd200, 32'd400);
    send(REQ_ADD, 16'sd300, 32'hFFFF_FFF0);
    send(REQ_ADD, 16'sd400, 32'h0000_0010);
    send(REQ_ADD, -16'sd1, 32'h0000_0008);
    send(REQ_ADD, 16'sh7FFF, 32'hFFFF_FFFF);
    send(REQ_ADD, -16'sh8000, 32'h0000_0000);
    send(REQ_CLEAR, 16'shFFFF, 32'hFFFF_FFFF);
    send(REQ_ADD, 16'sd5, 32'd7);
    send(REQ_ADD, 16'sd9, 32'd7);
    send(REQ_ADD, 16'sd1, 32'd8);
    drain();

    // phases over several window settings
    for (int p = 0; p < 7; p++) begin
      if (p > 0) begin
        write_cfg(CFG_SHORT_WINDOW, wins[p][0]);
        write_cfg(CFG_LONG_WINDOW, wins[p][1]);
        if (p == 3) write_cfg(CFG_IDX_W'(2), 8'hAA);
        if (p == 5) write_cfg(CFG_IDX_W'(255), 8'h55);
      end
      calm = (p == 4);
      for (int k = 0; k < 276; k++) begin
        if (p == 2 && k == 140) drain();
        add_random();
      end
      drain();
    end

    calm = 1'b0;
    repeat (1000) @(posedge clk);
    if (sb.failures == 0 && sb.pending.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
